// ----- sv/nidcv_pkg.sv -----
package nidcv_pkg;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   // identifier layout
   localparam logic [3:0] ID_LENGTH    = 4'd10;
   localparam logic [3:0] POS_MAX      = 4'd15;
   localparam logic [3:0] POS_CHECK    = 4'd9;
   localparam logic [3:0] MODULUS      = 4'd11;
   localparam logic [3:0] SUM_TEN      = 4'd10;

   // day limits
   localparam logic [6:0] DAYS_LONG    = 7'd31;
   localparam logic [6:0] DAYS_SHORT   = 7'd30;
   localparam logic [6:0] DAYS_FEB     = 7'd28;
   localparam logic [6:0] DAYS_FEB_LEAP = 7'd29;

   // accumulated state of the line being read
   typedef struct packed {
      logic [3:0] position;
      logic [3:0] sum_mod_eleven;
      logic [6:0] year_digits;
      logic [6:0] month_digits;
      logic [6:0] day_digits;
      logic [3:0] check_digit;
      logic       all_digits;
   } nidcv_state_type;

   // weight of the digit at a given position (positions 0 to 8)
   function automatic logic [3:0] digit_weight(input logic [3:0] pos);
      logic [3:0] w;
      begin
         case (pos)
            4'd0: w = 4'd2;
            4'd1: w = 4'd4;
            4'd2: w = 4'd8;
            4'd3: w = 4'd5;
            4'd4: w = 4'd10;
            4'd5: w = 4'd9;
            4'd6: w = 4'd7;
            4'd7: w = 4'd3;
            4'd8: w = 4'd6;
            default: w = 4'd0;
         endcase
         digit_weight = w;
      end
   endfunction

   // remainder by eleven for values up to 127, via reciprocal 187/2048
   function automatic logic [3:0] mod_eleven(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [7:0]  r;
      begin
         prod = 15'(v) * 15'd187;
         q = prod[14:11];
         r = 8'(v) - 8'(q) * 8'(MODULUS);
         if (r >= 8'(MODULUS)) begin
            r = r - 8'(MODULUS);
         end
         mod_eleven = r[3:0];
      end
   endfunction

endpackage

// ----- sv/national_id_check_validator_unit.sv -----
// ten-digit personal identifier checker, one character per word
//
// req channel: req_symbol carries one character byte per word; a newline
// ends the identifier. rsp channel: one word per newline, rsp_valid_res is
// 1 when the line had exactly ten digits, a valid date and a matching
// check digit, else 0. Characters other than newline give no rsp word.
//
// a req word is captured in an input register and from there folded into
// the running state; for a newline, the verdict is registered in the
// result register, which drives rsp_valid, once that register is free.
// One word is accepted every cycle unless a newline waits on a stalled
// rsp; the state update is a single weighted add and a reduction by eleven.
//
// while rsp is stalled, ordinary characters keep flowing; a second newline
// waits in the input register and req_ready falls until rsp is taken.
// reset (synchronous, active high) empties both registers and clears the
// line state.
module national_id_check_validator_unit
   import nidcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_valid_res
);

   logic            in_valid_ff;
   logic [7:0]      in_symbol_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_res_ff;
   logic            is_newline;
   logic            out_free;
   logic            advance;
   logic            pass;
   nidcv_state_type state;

   // handshake control
   assign is_newline = (in_symbol_ff == CHAR_NEWLINE);
   assign out_free   = !out_valid_ff || rsp_ready;
   assign advance    = in_valid_ff && (!is_newline || out_free);
   assign req_ready  = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_symbol_ff <= req_symbol;
      end
   end

   // line state
   nidcv_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance && !is_newline),
      .clear  (advance && is_newline),
      .symbol (in_symbol_ff),
      .state  (state)
   );

   // verdict on the finished line
   nidcv_judge u_judge (
      .state (state),
      .pass  (pass)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance && is_newline) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_newline) begin
         out_res_ff <= pass;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_valid_res = out_res_ff;

endmodule

// ----- sv/nidcv_accum.sv -----
module nidcv_accum
   import nidcv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            clear,
   input  logic [7:0]      symbol,
   output nidcv_state_type state
);

   nidcv_state_type state_ff;
   nidcv_state_type state_in;

   logic       is_digit;
   logic [3:0] digit;
   logic [6:0] weighted;
   logic [6:0] two_digit_acc;
   logic [6:0] two_digit_res;

   assign is_digit = symbol inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit    = 4'(symbol - CHAR_ZERO);

   // running weighted sum, reduced by eleven
   assign weighted = 7'(state_ff.sum_mod_eleven) + 7'(digit) * 7'(digit_weight(state_ff.position));

   // pick the two-digit field for this position and shift in the digit
   always_comb begin
      case (state_ff.position)
         4'd0, 4'd1: two_digit_acc = state_ff.year_digits;
         4'd2, 4'd3: two_digit_acc = state_ff.month_digits;
         4'd4, 4'd5: two_digit_acc = state_ff.day_digits;
         default:    two_digit_acc = 7'd0;
      endcase
   end

   assign two_digit_res = 7'((two_digit_acc << 3) + (two_digit_acc << 1) + 7'(digit));

   // next state
   always_comb begin
      state_in = state_ff;
      if (clear) begin
         state_in            = '0;
         state_in.all_digits = 1'b1;
      end else if (step) begin
         if (is_digit) begin
            if (state_ff.position < POS_CHECK) begin
               state_in.sum_mod_eleven = mod_eleven(weighted);
            end
            case (state_ff.position)
               4'd0, 4'd1: state_in.year_digits  = two_digit_res;
               4'd2, 4'd3: state_in.month_digits = two_digit_res;
               4'd4, 4'd5: state_in.day_digits   = two_digit_res;
               POS_CHECK:  state_in.check_digit  = digit;
               default:    state_in.check_digit  = state_ff.check_digit;
            endcase
         end else begin
            state_in.all_digits = 1'b0;
         end
         if (state_ff.position != POS_MAX) begin
            state_in.position = state_ff.position + 4'd1;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= '0;
         state_ff.all_digits <= 1'b1;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ----- sv/nidcv_judge.sv -----
module nidcv_judge
   import nidcv_pkg::*;
(
   input  nidcv_state_type state,
   output logic            pass
);

   logic [6:0] month;
   logic       month_ok;
   logic [6:0] limit;
   logic [3:0] expect_digit;
   logic       date_ok;

   // fold the month offsets of 20 and 40 back to 1 to 12
   always_comb begin
      month_ok = 1'b1;
      month    = state.month_digits;
      if (state.month_digits inside {[7'd41:7'd52]}) begin
         month = state.month_digits - 7'd40;
      end else if (state.month_digits inside {[7'd21:7'd32]}) begin
         month = state.month_digits - 7'd20;
      end else if (!(state.month_digits inside {[7'd1:7'd12]})) begin
         month_ok = 1'b0;
      end
   end

   // days in the month
   always_comb begin
      if (month == 7'd2) begin
         limit = (state.year_digits[1:0] == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
      end else if (month inside {7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12}) begin
         limit = DAYS_LONG;
      end else begin
         limit = DAYS_SHORT;
      end
   end

   assign date_ok = month_ok && (state.day_digits != 7'd0) && (state.day_digits <= limit);

   // a remainder of ten counts as zero
   assign expect_digit = (state.sum_mod_eleven == SUM_TEN) ? 4'd0 : state.sum_mod_eleven;

   assign pass = (state.position == ID_LENGTH) && state.all_digits && date_ok &&
                 (state.check_digit == expect_digit);

endmodule
